[hw/rtl/svpc_pkg.sv]
// Shared types, register indexes and helpers for the sensor vector plausibility check.
package svpc_pkg;

    localparam int AXIS_W   = 16;
    localparam int AXES     = 3;
    localparam int VEC_W    = AXIS_W * AXES;
    localparam int MAG_W    = AXIS_W + 1;
    localparam int NORM_W   = 32;
    localparam int CNT_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [VEC_W-1:0]  t_vec;
    typedef logic [MAG_W-1:0]  t_mag;
    typedef logic [NORM_W-1:0] t_norm;

    // closed squared-norm window
    typedef struct packed {
        t_norm lo;
        t_norm hi;
    } t_win;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_MAX    = 3'd6;

    localparam logic [AXIS_W-1:0] GYRO_LIMIT_RST = 16'h8000;
    localparam t_norm             NORM_MIN_RST   = 32'd0;
    localparam t_norm             NORM_MAX_RST   = 32'hC000_0000;

    localparam logic [1:0] SRC_UNKNOWN   = 2'd0;
    localparam logic [1:0] SRC_SIMULATED = 2'd1;
    localparam logic [1:0] SRC_BOARD     = 2'd2;
    localparam logic [1:0] SRC_STUB      = 2'd3;

    // magnitude of one two's-complement axis, 0..32768
    function automatic t_mag axis_abs(input t_vec vec, input int k);
        logic [AXIS_W-1:0] raw;
        raw = vec[k*AXIS_W +: AXIS_W];
        if (raw[AXIS_W-1]) begin
            return t_mag'(17'h10000 - {1'b0, raw});
        end
        return {1'b0, raw};
    endfunction

endpackage

[hw/rtl/svpc_norm_window.sv]
// Squared-norm window check for one 3-axis sensor vector.
module svpc_norm_window (
    input  logic          i_flag,
    input  svpc_pkg::t_vec i_vector,
    input  svpc_pkg::t_win i_win,
    output logic          o_good
);
    import svpc_pkg::*;

    t_mag                mag   [AXES];
    logic [2*MAG_W-1:0]  prod  [AXES];
    t_norm               norm_sq;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            mag[k]  = axis_abs(i_vector, k);
            prod[k] = mag[k] * mag[k];
        end
        // each square is at most 2^30, so the sum fits 32 bits exactly
        norm_sq = prod[0][NORM_W-1:0] + prod[1][NORM_W-1:0] + prod[2][NORM_W-1:0];
        o_good  = i_flag && (norm_sq >= i_win.lo) && (norm_sq <= i_win.hi);
    end

endmodule

[hw/rtl/svpc_gyro_check.sv]
// Per-axis magnitude limit check for the gyro vector.
module svpc_gyro_check (
    input  logic                          i_flag,
    input  svpc_pkg::t_vec                i_vector,
    input  logic [svpc_pkg::AXIS_W-1:0]   i_limit,
    output logic                          o_good
);
    import svpc_pkg::*;

    logic [AXES-1:0] axis_ok;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            axis_ok[k] = axis_abs(i_vector, k) <= {1'b0, i_limit};
        end
        o_good = i_flag && (&axis_ok);
    end

endmodule

[hw/rtl/sensor_vector_plausibility_check.sv]
// Top level of the sensor vector plausibility check.
//
// Input channel: one sensor packet per beat (source code, four flags and four
// packed 3-axis vectors), i_in_valid / o_in_ready. Output channel: one result
// per packet (cleaned vectors, pass bits, running counts), o_out_valid /
// i_out_ready. Configuration: i_cfg_we writes i_cfg_data to register
// i_cfg_index at the clock edge; indexes past the list are ignored.
//
// Throughput: one packet per cycle while the receiver takes results. Path: a
// packet accepted lands in the input register, and its result is shown once it
// moves on into the result register. The squared norms (three 17x17 multiplies
// and a 32-bit add per windowed sensor: accel, sun and mag) and the window
// compares sit between the input register and the result register.
// Reset (synchronous, active low) empties both stages, clears the checked and
// rejected counts and loads the register defaults. When the receiver stalls,
// the result holds; the input register still takes one more packet, and
// o_in_ready drops only when both stages are full.
module sensor_vector_plausibility_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [svpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [svpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_source_code,
    input  logic                              i_gyro_flag,
    input  logic [47:0]                       i_gyro_vector,
    input  logic                              i_accel_flag,
    input  logic [47:0]                       i_accel_vector,
    input  logic                              i_sun_flag,
    input  logic [47:0]                       i_sun_vector,
    input  logic                              i_mag_flag,
    input  logic [47:0]                       i_mag_vector,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [47:0]                       o_gyro_clean,
    output logic [47:0]                       o_accel_clean,
    output logic [47:0]                       o_sun_clean,
    output logic [47:0]                       o_mag_clean,
    output logic                              o_source_good,
    output logic                              o_gyro_good,
    output logic                              o_accel_good,
    output logic                              o_sun_good,
    output logic                              o_mag_good,
    output logic                              o_packet_good,
    output logic [31:0]                       o_checked_count,
    output logic [31:0]                       o_rejected_count
);
    import svpc_pkg::*;

    // configuration
    logic [AXIS_W-1:0] r_gyro_limit;
    t_win              r_accel_win;
    t_win              r_sun_win;
    t_win              r_mag_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_limit <= GYRO_LIMIT_RST;
            r_accel_win  <= '{lo: NORM_MIN_RST, hi: NORM_MAX_RST};
            r_sun_win    <= '{lo: NORM_MIN_RST, hi: NORM_MAX_RST};
            r_mag_win    <= '{lo: NORM_MIN_RST, hi: NORM_MAX_RST};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GYRO_LIMIT: r_gyro_limit   <= i_cfg_data[AXIS_W-1:0];
                CFG_ACCEL_MIN:  r_accel_win.lo <= i_cfg_data;
                CFG_ACCEL_MAX:  r_accel_win.hi <= i_cfg_data;
                CFG_SUN_MIN:    r_sun_win.lo   <= i_cfg_data;
                CFG_SUN_MAX:    r_sun_win.hi   <= i_cfg_data;
                CFG_MAG_MIN:    r_mag_win.lo   <= i_cfg_data;
                CFG_MAG_MAX:    r_mag_win.hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic out_load;
    logic in_load;

    assign out_load   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || out_load;
    assign in_load    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input register
    logic [1:0] r_s1_source;
    logic       r_s1_gyro_flag;
    logic       r_s1_accel_flag;
    logic       r_s1_sun_flag;
    logic       r_s1_mag_flag;
    t_vec       r_s1_gyro;
    t_vec       r_s1_accel;
    t_vec       r_s1_sun;
    t_vec       r_s1_mag;

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_s1_source     <= i_source_code;
            r_s1_gyro_flag  <= i_gyro_flag;
            r_s1_accel_flag <= i_accel_flag;
            r_s1_sun_flag   <= i_sun_flag;
            r_s1_mag_flag   <= i_mag_flag;
            r_s1_gyro       <= i_gyro_vector;
            r_s1_accel      <= i_accel_vector;
            r_s1_sun        <= i_sun_vector;
            r_s1_mag        <= i_mag_vector;
        end
    end

    // checks
    logic gyro_ok;
    logic accel_pass;
    logic sun_ok;
    logic mag_ok;
    logic src_ok;
    logic pkt_ok;

    svpc_gyro_check u_gyro (
        .i_flag   (r_s1_gyro_flag),
        .i_vector (r_s1_gyro),
        .i_limit  (r_gyro_limit),
        .o_good   (gyro_ok)
    );

    svpc_norm_window u_accel (
        .i_flag   (r_s1_accel_flag),
        .i_vector (r_s1_accel),
        .i_win    (r_accel_win),
        .o_good   (accel_pass)
    );

    svpc_norm_window u_sun (
        .i_flag   (r_s1_sun_flag),
        .i_vector (r_s1_sun),
        .i_win    (r_sun_win),
        .o_good   (sun_ok)
    );

    svpc_norm_window u_mag (
        .i_flag   (r_s1_mag_flag),
        .i_vector (r_s1_mag),
        .i_win    (r_mag_win),
        .o_good   (mag_ok)
    );

    assign src_ok = r_s1_source != SRC_UNKNOWN;
    assign pkt_ok = src_ok && gyro_ok && accel_pass;

    // result register; the tallies live here: checked steps with each result, rejected with each failing one
    t_vec             r_gyro_clean;
    t_vec             r_accel_clean;
    t_vec             r_sun_clean;
    t_vec             r_mag_clean;
    logic             r_source_good;
    logic             r_gyro_good;
    logic             r_accel_good;
    logic             r_sun_good;
    logic             r_mag_good;
    logic             r_packet_good;
    logic [CNT_W-1:0] r_checked;
    logic [CNT_W-1:0] r_rejected;
    logic [CNT_W-1:0] n_checked;
    logic [CNT_W-1:0] n_rejected;

    assign n_checked  = r_checked + CNT_W'(1);
    assign n_rejected = pkt_ok ? r_rejected : r_rejected + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checked  <= '0;
            r_rejected <= '0;
        end else if (out_load) begin
            r_checked  <= n_checked;
            r_rejected <= n_rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_gyro_clean  <= gyro_ok    ? r_s1_gyro  : '0;
            r_accel_clean <= accel_pass ? r_s1_accel : '0;
            r_sun_clean   <= sun_ok     ? r_s1_sun   : '0;
            r_mag_clean   <= mag_ok     ? r_s1_mag   : '0;
            r_source_good <= src_ok;
            r_gyro_good   <= gyro_ok;
            r_accel_good  <= accel_pass;
            r_sun_good    <= sun_ok;
            r_mag_good    <= mag_ok;
            r_packet_good <= pkt_ok;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_gyro_clean     = r_gyro_clean;
    assign o_accel_clean    = r_accel_clean;
    assign o_sun_clean      = r_sun_clean;
    assign o_mag_clean      = r_mag_clean;
    assign o_source_good    = r_source_good;
    assign o_gyro_good      = r_gyro_good;
    assign o_accel_good     = r_accel_good;
    assign o_sun_good       = r_sun_good;
    assign o_mag_good       = r_mag_good;
    assign o_packet_good    = r_packet_good;
    assign o_checked_count  = r_checked;
    assign o_rejected_count = r_rejected;

endmodule

[hw/rtl/svpc_checker.sv]
// Port-level checker for the sensor vector plausibility check, with its bind.
module svpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [47:0] o_gyro_clean,
    input logic [47:0] o_accel_clean,
    input logic        o_source_good,
    input logic        o_gyro_good,
    input logic        o_accel_good,
    input logic        o_packet_good,
    input logic [31:0] o_checked_count
);

    // nothing comes out of a freshly reset block
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled beat keeps its count
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_checked_count))
        else $error("stalled result changed");

    // packet verdict and the gyro and accel cleaned vectors agree with the per-sensor bits
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_packet_good == (o_source_good && o_gyro_good && o_accel_good))
                        && (o_gyro_good || o_gyro_clean == 48'd0)
                        && (o_accel_good || o_accel_clean == 48'd0))
        else $error("packet verdict inconsistent");

    // consecutive results carry consecutive counts
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) ##1 o_out_valid
            |-> o_checked_count == $past(o_checked_count) + 32'd1)
        else $error("checked count skipped");

endmodule

bind sensor_vector_plausibility_check svpc_checker u_svpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_gyro_clean    (o_gyro_clean),
    .o_accel_clean   (o_accel_clean),
    .o_source_good   (o_source_good),
    .o_gyro_good     (o_gyro_good),
    .o_accel_good    (o_accel_good),
    .o_packet_good   (o_packet_good),
    .o_checked_count (o_checked_count)
);

[tb/sensor_vector_plausibility_check_test.sv]
// Testbench for the sensor vector plausibility check: directed and random packets vs. a predictor.
`timescale 1ns / 1ps

module sensor_vector_plausibility_check_test;
    import svpc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum int {SENS_GYRO, SENS_ACCEL, SENS_SUN, SENS_MAG} t_sensor;

    typedef struct {
        logic [1:0] src;
        logic [3:0] flag;
        t_vec       vec[4];
    } t_packet;

    typedef struct {
        t_vec        clean[4];
        logic [3:0]  good;
        logic        source_good;
        logic        packet_good;
        logic [31:0] checked;
        logic [31:0] rejected;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_source_code;
    logic        i_gyro_flag, i_accel_flag, i_sun_flag, i_mag_flag;
    logic [47:0] i_gyro_vector, i_accel_vector, i_sun_vector, i_mag_vector;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [47:0] o_gyro_clean, o_accel_clean, o_sun_clean, o_mag_clean;
    logic        o_source_good, o_gyro_good, o_accel_good, o_sun_good, o_mag_good;
    logic        o_packet_good;
    logic [31:0] o_checked_count, o_rejected_count;

    sensor_vector_plausibility_check u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_source_code    (i_source_code),
        .i_gyro_flag      (i_gyro_flag),
        .i_gyro_vector    (i_gyro_vector),
        .i_accel_flag     (i_accel_flag),
        .i_accel_vector   (i_accel_vector),
        .i_sun_flag       (i_sun_flag),
        .i_sun_vector     (i_sun_vector),
        .i_mag_flag       (i_mag_flag),
        .i_mag_vector     (i_mag_vector),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_gyro_clean     (o_gyro_clean),
        .o_accel_clean    (o_accel_clean),
        .o_sun_clean      (o_sun_clean),
        .o_mag_clean      (o_mag_clean),
        .o_source_good    (o_source_good),
        .o_gyro_good      (o_gyro_good),
        .o_accel_good     (o_accel_good),
        .o_sun_good       (o_sun_good),
        .o_mag_good       (o_mag_good),
        .o_packet_good    (o_packet_good),
        .o_checked_count  (o_checked_count),
        .o_rejected_count (o_rejected_count)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the block's registers and tallies
    logic [15:0] gyro_limit_cfg = GYRO_LIMIT_RST;
    t_norm       win_lo[4] = '{NORM_MIN_RST, NORM_MIN_RST, NORM_MIN_RST, NORM_MIN_RST};
    t_norm       win_hi[4] = '{NORM_MAX_RST, NORM_MAX_RST, NORM_MAX_RST, NORM_MAX_RST};
    logic [31:0] checked_tally = 0;
    logic [31:0] rejected_tally = 0;

    t_verdict pending_verdicts[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       stall_left = 0;
    bit       sender_idling = 1'b1;
    bit       receiver_idling = 1'b1;

    function automatic t_verdict grade_packet(input t_packet p);
        t_verdict    r;
        logic [15:0] raw;
        logic [16:0] sx;
        logic [16:0] mag[3];
        t_norm       n;
        logic        ok;
        for (int s = 0; s < 4; s++) begin
            n = '0;
            for (int k = 0; k < 3; k++) begin
                raw = p.vec[s][16*k +: 16];
                sx = {raw[15], raw};
                mag[k] = sx[16] ? 17'(-sx) : sx;
                n = n + t_norm'(mag[k]) * t_norm'(mag[k]);
            end
            if (s == SENS_GYRO) begin
                ok = p.flag[s] && mag[0] <= {1'b0, gyro_limit_cfg}
                     && mag[1] <= {1'b0, gyro_limit_cfg} && mag[2] <= {1'b0, gyro_limit_cfg};
            end else begin
                ok = p.flag[s] && n >= win_lo[s] && n <= win_hi[s];
            end
            r.good[s] = ok;
            r.clean[s] = ok ? p.vec[s] : '0;
        end
        r.source_good = p.src != SRC_UNKNOWN;
        r.packet_good = r.source_good && r.good[SENS_GYRO] && r.good[SENS_ACCEL];
        r.checked = '0;
        r.rejected = '0;
        return r;
    endfunction

    function automatic t_vec vec3(input logic [15:0] x, input logic [15:0] y,
                                  input logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic t_packet make_packet(input logic [1:0] src, input logic [3:0] flags,
                                            input t_vec g, input t_vec a,
                                            input t_vec s, input t_vec m);
        t_packet p;
        p.src = src;
        p.flag = flags;
        p.vec[SENS_GYRO] = g;
        p.vec[SENS_ACCEL] = a;
        p.vec[SENS_SUN] = s;
        p.vec[SENS_MAG] = m;
        return p;
    endfunction

    // mix of full-range, log-spread, corner and near-gyro-limit axis values
    function automatic logic [15:0] pick_axis();
        logic [15:0] mag;
        int          k;
        int          m;
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: begin
                k = $urandom_range(0, 15);
                mag = 16'($urandom_range(0, (1 << k) - 1));
                return $urandom_range(0, 1) ? 16'(-mag) : mag;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h8001;
                endcase
            end
            default: begin
                m = int'(gyro_limit_cfg) - 1 + $urandom_range(0, 2);
                if (m < 0) m = 0;
                if (m > 32768) m = 32768;
                return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
            end
        endcase
    endfunction

    function automatic t_vec pick_vector();
        return vec3(pick_axis(), pick_axis(), pick_axis());
    endfunction

    function automatic t_packet pick_packet();
        t_packet p;
        p.src = 2'($urandom_range(0, 3));
        for (int s = 0; s < 4; s++) begin
            p.flag[s] = $urandom_range(0, 7) != 0;
            p.vec[s] = pick_vector();
        end
        return p;
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 6))
            0: return 16'($urandom);
            1: return GYRO_LIMIT_RST;
            2: return 16'h7FFF;
            3: return 16'h0000;
            4: return 16'hFFFF;
            5: return 16'($urandom_range(0, 64));
            default: return 16'($urandom_range(0, (1 << $urandom_range(1, 15)) - 1));
        endcase
    endfunction

    task automatic pick_window(output t_norm lo, output t_norm hi);
        int              a;
        int              b;
        longint unsigned top;
        case ($urandom_range(0, 5))
            0: begin lo = NORM_MIN_RST; hi = NORM_MAX_RST; end
            1: begin
                // inverted window: nothing passes
                hi = $urandom_range(0, 32'hBFFF_FFFF);
                lo = hi + 32'($urandom_range(1, 1000));
            end
            2: begin lo = NORM_MAX_RST; hi = NORM_MAX_RST; end
            3: begin lo = '0; hi = '0; end
            default: begin
                a = $urandom_range(0, 31);
                b = $urandom_range(a, 31);
                lo = $urandom_range(0, 32'((64'd1 << a) - 1));
                top = (64'd1 << b) + $urandom_range(0, 32'((64'd1 << b) - 1));
                if (top > NORM_MAX_RST) top = NORM_MAX_RST;
                hi = t_norm'(top);
            end
        endcase
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_GYRO_LIMIT: gyro_limit_cfg = data[15:0];
            CFG_ACCEL_MIN:  win_lo[SENS_ACCEL] = data;
            CFG_ACCEL_MAX:  win_hi[SENS_ACCEL] = data;
            CFG_SUN_MIN:    win_lo[SENS_SUN] = data;
            CFG_SUN_MAX:    win_hi[SENS_SUN] = data;
            CFG_MAG_MIN:    win_lo[SENS_MAG] = data;
            CFG_MAG_MAX:    win_hi[SENS_MAG] = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_packet(input t_packet p);
        t_verdict v;
        if (sender_idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_source_code <= p.src;
        i_gyro_flag <= p.flag[SENS_GYRO];
        i_gyro_vector <= p.vec[SENS_GYRO];
        i_accel_flag <= p.flag[SENS_ACCEL];
        i_accel_vector <= p.vec[SENS_ACCEL];
        i_sun_flag <= p.flag[SENS_SUN];
        i_sun_vector <= p.vec[SENS_SUN];
        i_mag_flag <= p.flag[SENS_MAG];
        i_mag_vector <= p.vec[SENS_MAG];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        v = grade_packet(p);
        checked_tally++;
        if (!v.packet_good) rejected_tally++;
        v.checked = checked_tally;
        v.rejected = rejected_tally;
        pending_verdicts.push_back(v);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic restore_defaults();
        write_register(CFG_GYRO_LIMIT, 32'(GYRO_LIMIT_RST));
        write_register(CFG_ACCEL_MIN, NORM_MIN_RST);
        write_register(CFG_ACCEL_MAX, NORM_MAX_RST);
        write_register(CFG_SUN_MIN, NORM_MIN_RST);
        write_register(CFG_SUN_MAX, NORM_MAX_RST);
        write_register(CFG_MAG_MIN, NORM_MIN_RST);
        write_register(CFG_MAG_MAX, NORM_MAX_RST);
    endtask

    task automatic test_defaults();
        t_vec neg = vec3(16'h8000, 16'h8000, 16'h8000);
        t_vec pos = vec3(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, '0, '0, '0, '0));
        // most negative axes: magnitude 32768, norm exactly at the ceiling
        send_packet(make_packet(SRC_BOARD, 4'b1111, neg, neg, neg, neg));
        send_packet(make_packet(SRC_STUB, 4'b1111, pos, pos, pos, pos));
        send_packet(make_packet(SRC_UNKNOWN, 4'b1111, '0, '0, '0, '0));
        send_packet(make_packet(SRC_SIMULATED, 4'b0000, pick_vector(), pick_vector(),
                                pick_vector(), pick_vector()));
        send_packet(make_packet(SRC_SIMULATED, 4'b1010, pos, pos, pos, pos));
        send_packet(make_packet(SRC_BOARD, 4'b0101, neg, neg, neg, neg));
    endtask

    task automatic test_gyro_limit();
        drain_results();
        write_register(CFG_GYRO_LIMIT, 32'h0000_7FFF);
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, vec3(16'h8000, 16'd0, 16'd0),
                                '0, '0, '0));
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, vec3(16'd0, 16'h7FFF, 16'h8001),
                                '0, '0, '0));
        drain_results();
        write_register(CFG_GYRO_LIMIT, 32'h0000_0000);
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, '0, '0, '0, '0));
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, vec3(16'd0, 16'd0, 16'h0001),
                                '0, '0, '0));
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, vec3(16'hFFFF, 16'd0, 16'd0),
                                '0, '0, '0));
        drain_results();
        // limit above the axis range behaves as 32768
        write_register(CFG_GYRO_LIMIT, 32'h0000_FFFF);
        send_packet(make_packet(SRC_STUB, 4'b1111, vec3(16'h8000, 16'h8000, 16'h8000),
                                '0, '0, '0));
        drain_results();
        // upper data bits fall outside the 16-bit register
        write_register(CFG_GYRO_LIMIT, 32'h0001_0005);
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, vec3(16'h0005, 16'hFFFB, 16'd0),
                                '0, '0, '0));
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, vec3(16'd0, 16'h0006, 16'd0),
                                '0, '0, '0));
        drain_results();
        write_register(CFG_GYRO_LIMIT, 32'(GYRO_LIMIT_RST));
    endtask

    task automatic test_windows();
        t_vec neg = vec3(16'h8000, 16'h8000, 16'h8000);
        drain_results();
        write_register(CFG_ACCEL_MIN, 32'd25);
        write_register(CFG_ACCEL_MAX, 32'd25);
        write_register(CFG_SUN_MIN, 32'd100);
        write_register(CFG_SUN_MAX, 32'd99);
        write_register(CFG_MAG_MIN, NORM_MAX_RST);
        write_register(CFG_MAG_MAX, NORM_MAX_RST);
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, '0, vec3(16'd3, 16'd4, 16'd0),
                                vec3(16'd10, 16'd0, 16'd0), neg));
        send_packet(make_packet(SRC_SIMULATED, 4'b1111, '0, vec3(16'd3, 16'hFFFC, 16'd1), '0,
                                vec3(16'h8000, 16'h8000, 16'h7FFF)));
        send_packet(make_packet(SRC_BOARD, 4'b1111, '0, vec3(16'd0, 16'hFFFB, 16'd0), '0,
                                neg));
        drain_results();
        // write to an index past the list must leave every register alone
        write_register(CFG_UNUSED, 32'h0000_0000);
        send_packet(make_packet(SRC_STUB, 4'b1111, '0, vec3(16'd3, 16'd4, 16'd0),
                                vec3(16'd10, 16'd0, 16'd0), neg));
        drain_results();
        restore_defaults();
    endtask

    task automatic test_random_phases();
        t_norm lo;
        t_norm hi;
        for (int phase = 0; phase < 8; phase++) begin
            drain_results();
            write_register(CFG_GYRO_LIMIT, 32'(pick_limit()));
            pick_window(lo, hi);
            write_register(CFG_ACCEL_MIN, lo);
            write_register(CFG_ACCEL_MAX, hi);
            pick_window(lo, hi);
            write_register(CFG_SUN_MIN, lo);
            write_register(CFG_SUN_MAX, hi);
            pick_window(lo, hi);
            write_register(CFG_MAG_MIN, lo);
            write_register(CFG_MAG_MAX, hi);
            if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED, $urandom);
            repeat (150) send_packet(pick_packet());
        end
    endtask

    task automatic test_back_to_back();
        sender_idling = 1'b0;
        receiver_idling = 1'b0;
        repeat (150) send_packet(pick_packet());
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no packet pending");
                mismatch_count++;
            end else begin
                v = pending_verdicts.pop_front();
                check_field("gyro_clean", v.clean[SENS_GYRO], o_gyro_clean);
                check_field("accel_clean", v.clean[SENS_ACCEL], o_accel_clean);
                check_field("sun_clean", v.clean[SENS_SUN], o_sun_clean);
                check_field("mag_clean", v.clean[SENS_MAG], o_mag_clean);
                check_field("source_good", 48'(v.source_good), 48'(o_source_good));
                check_field("gyro_good", 48'(v.good[SENS_GYRO]), 48'(o_gyro_good));
                check_field("accel_good", 48'(v.good[SENS_ACCEL]), 48'(o_accel_good));
                check_field("sun_good", 48'(v.good[SENS_SUN]), 48'(o_sun_good));
                check_field("mag_good", 48'(v.good[SENS_MAG]), 48'(o_mag_good));
                check_field("packet_good", 48'(v.packet_good), 48'(o_packet_good));
                check_field("checked_count", 48'(v.checked), 48'(o_checked_count));
                check_field("rejected_count", 48'(v.rejected), 48'(o_rejected_count));
            end
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_out_ready <= 1'b1;
        i_source_code <= '0;
        i_gyro_flag <= 1'b0;
        i_gyro_vector <= '0;
        i_accel_flag <= 1'b0;
        i_accel_vector <= '0;
        i_sun_flag <= 1'b0;
        i_sun_vector <= '0;
        i_mag_flag <= 1'b0;
        i_mag_vector <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_gyro_limit();
        test_windows();
        test_random_phases();
        test_back_to_back();

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/svpc_pkg.sv
hw/rtl/svpc_norm_window.sv
hw/rtl/svpc_gyro_check.sv
hw/rtl/sensor_vector_plausibility_check.sv
hw/rtl/svpc_checker.sv
tb/sensor_vector_plausibility_check_test.sv
